// File: hw/rtl/cbbe_pkg.sv
`default_nettype none

package cbbe_pkg;

   // defaults for the top level parameters
   localparam int MAX_CLUSTERS_DEF = 16;
   localparam int COORD_BITS_DEF   = 24;
   localparam int COEFF_BITS_DEF   = 18;

   // fixed field widths
   localparam int LABEL_BITS     = 4;
   localparam int LABEL_EXT_BITS = 9;   // holds any cluster count up to 256
   localparam int REQ_TYPE_BITS  = 2;
   localparam int CORNER_BITS    = 3;
   localparam int MARGIN_BITS    = 16;
   localparam int CSR_ADDR_BITS  = 2;

   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd983;
   localparam logic [CORNER_BITS-1:0] LAST_CORNER  = 3'd7;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_ADD   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_ROT_ROW_ZERO  = 2'd0,
      CSR_ROT_ROW_ONE   = 2'd1,
      CSR_ROT_ROW_TWO   = 2'd2,
      CSR_HEIGHT_MARGIN = 2'd3
   } csr_index_type;

   // side info carried along the forward rotation
   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0] kind;
      logic [LABEL_BITS-1:0]    label;
   } req_tag_type;

   // side info carried along the corner rotation
   typedef struct packed {
      logic                   last;
      logic                   empty;
      logic [CORNER_BITS-1:0] index;
   } corner_tag_type;

endpackage

`default_nettype wire

// File: hw/rtl/cluster_bounding_box_engine_top.sv
`default_nettype none

// channel    | dir | handshake               | payload
// -----------+-----+-------------------------+-------------------------------------------
// req_       | in  | req_tvalid / req_tready | tdata: point_x, point_y, point_z, label
//            |     |                         | tuser: req_type
// rsp_       | out | rsp_tvalid / rsp_tready | tdata: corner_x, corner_y, corner_z
//            |     |                         | tuser: corner_index, cluster_empty
//            |     |                         | tlast: last_corner
// csr_       | in  | csr_wen                 | csr_addr, csr_wdata
//
// add and clear requests are taken one per cycle while no read is open; each runs
// through the two-stage forward rotation and then updates the extent table
// a read request holds req_tready low until its eighth corner is taken: the read runs
// through the forward rotation and loads the corner sequencer, then the corners leave
// through the back rotation one a cycle while rsp_tready stays high
// a low rsp_tready stalls the corner sequencer and the back rotation as one pipe
// reset is synchronous and active high: it empties every cluster at once through the
// occupied marks and brings back the identity rotation and the default margin

module cluster_bounding_box_engine_top #(
   parameter int MAX_CLUSTERS = cbbe_pkg::MAX_CLUSTERS_DEF,
   parameter int COORD_BITS   = cbbe_pkg::COORD_BITS_DEF,
   parameter int COEFF_BITS   = cbbe_pkg::COEFF_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // point_x, point_y, point_z, cluster_label, zero pad
   input  logic [((3*COORD_BITS+cbbe_pkg::LABEL_BITS+7)/8)*8-1:0] req_tdata,
   // req_type
   input  logic [cbbe_pkg::REQ_TYPE_BITS-1:0] req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // corner_x, corner_y, corner_z, zero pad
   output logic [((3*COORD_BITS+7)/8)*8-1:0]  rsp_tdata,
   // corner_index, cluster_empty
   output logic [cbbe_pkg::CORNER_BITS:0]     rsp_tuser,
   output logic                               rsp_tlast,
   // configuration writes
   input  logic                               csr_wen,
   input  logic [cbbe_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [3*COEFF_BITS-1:0]            csr_wdata
);
   import cbbe_pkg::*;

   localparam int ROW_BITS   = 3 * COEFF_BITS;
   localparam int RSP_DATA_W = ((3*COORD_BITS+7)/8)*8;

   // configuration registers
   logic [ROW_BITS-1:0]    rot_row_ff[3];
   logic [MARGIN_BITS-1:0] margin_ff;

   // rotation matrix and its transpose
   logic signed [COEFF_BITS-1:0] fwd_coef[3][3];
   logic signed [COEFF_BITS-1:0] back_coef[3][3];

   // forward path
   logic                         req_accept;
   logic signed [COORD_BITS-1:0] fwd_vec[3];
   req_tag_type                  fwd_tag;
   logic                         fwd_out_valid;
   req_tag_type                  fwd_out_tag;
   logic signed [COORD_BITS-1:0] fwd_out_vec[3];

   // table to sequencer
   logic                         box_load;
   logic signed [COORD_BITS-1:0] box_lo[3];
   logic signed [COORD_BITS-1:0] box_hi[3];
   logic                         box_empty;

   // corner path
   logic                         adv;
   logic                         sel_valid;
   logic signed [COORD_BITS-1:0] sel_vec[3];
   corner_tag_type               sel_tag;
   corner_tag_type               rsp_tag;
   logic signed [COORD_BITS-1:0] rsp_vec[3];

   // set while a read is anywhere between accept and its last corner
   logic read_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            // identity: one in the diagonal coefficient of each row
            rot_row_ff[i] <= ROW_BITS'(1) << (COEFF_BITS - 2 + i * COEFF_BITS);
         end
         margin_ff <= MARGIN_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_ROT_ROW_ZERO:  rot_row_ff[0] <= csr_wdata;
            CSR_ROT_ROW_ONE:   rot_row_ff[1] <= csr_wdata;
            CSR_ROT_ROW_TWO:   rot_row_ff[2] <= csr_wdata;
            CSR_HEIGHT_MARGIN: margin_ff     <= csr_wdata[MARGIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // column zero sits in the low bits of each row
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            fwd_coef[i][j]  = rot_row_ff[i][j*COEFF_BITS +: COEFF_BITS];
            back_coef[j][i] = rot_row_ff[i][j*COEFF_BITS +: COEFF_BITS];
         end
      end
   end

   assign req_tready = !read_busy_ff;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fwd_vec[k] = req_tdata[k*COORD_BITS +: COORD_BITS];
      end
      fwd_tag.kind  = req_tuser;
      fwd_tag.label = req_tdata[3*COORD_BITS +: LABEL_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_busy_ff <= 1'b0;
      end else if (req_accept && (req_tuser == REQ_READ)) begin
         read_busy_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready && rsp_tag.last) begin
         read_busy_ff <= 1'b0;
      end
   end

   // world frame to plane frame, never stalls
   cbbe_rotate #(
      .COORD_BITS (COORD_BITS),
      .COEFF_BITS (COEFF_BITS),
      .TAG_BITS   ($bits(req_tag_type))
   ) u_fwd_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (1'b1),
      .in_valid  (req_accept),
      .in_tag    (fwd_tag),
      .in_vec    (fwd_vec),
      .coef      (fwd_coef),
      .out_valid (fwd_out_valid),
      .out_tag   (fwd_out_tag),
      .out_vec   (fwd_out_vec)
   );

   // per-label running extents, combinational read-modify with a registered write
   cbbe_extent_table #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .COORD_BITS   (COORD_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .upd_valid (fwd_out_valid),
      .upd_tag   (fwd_out_tag),
      .upd_q     (fwd_out_vec),
      .box_load  (box_load),
      .box_lo    (box_lo),
      .box_hi    (box_hi),
      .box_empty (box_empty)
   );

   // the back rotation's result register is the response register
   assign adv = !rsp_tvalid || rsp_tready;

   cbbe_corner_seq #(
      .COORD_BITS (COORD_BITS)
   ) u_corner_seq (
      .clock     (clock),
      .reset     (reset),
      .load      (box_load),
      .lo        (box_lo),
      .hi        (box_hi),
      .empty     (box_empty),
      .margin    (margin_ff),
      .adv       (adv),
      .sel_valid (sel_valid),
      .sel_vec   (sel_vec),
      .sel_tag   (sel_tag)
   );

   // plane frame back to world frame by the transpose
   cbbe_rotate #(
      .COORD_BITS (COORD_BITS),
      .COEFF_BITS (COEFF_BITS),
      .TAG_BITS   ($bits(corner_tag_type))
   ) u_back_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sel_valid),
      .in_tag    (sel_tag),
      .in_vec    (sel_vec),
      .coef      (back_coef),
      .out_valid (rsp_tvalid),
      .out_tag   (rsp_tag),
      .out_vec   (rsp_vec)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_vec[2], rsp_vec[1], rsp_vec[0]});
   assign rsp_tuser = {rsp_tag.empty, rsp_tag.index};
   assign rsp_tlast = rsp_tag.last;

endmodule

`default_nettype wire

// File: hw/rtl/cbbe_rotate.sv
`default_nettype none

module cbbe_rotate #(
   parameter int COORD_BITS = cbbe_pkg::COORD_BITS_DEF,
   parameter int COEFF_BITS = cbbe_pkg::COEFF_BITS_DEF,
   parameter int TAG_BITS   = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [TAG_BITS-1:0]          in_tag,
   input  logic signed [COORD_BITS-1:0] in_vec[3],
   input  logic signed [COEFF_BITS-1:0] coef[3][3],
   output logic                         out_valid,
   output logic [TAG_BITS-1:0]          out_tag,
   output logic signed [COORD_BITS-1:0] out_vec[3]
);
   import cbbe_pkg::*;

   localparam int PROD_BITS = COEFF_BITS + COORD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int FRAC_BITS = COEFF_BITS - 2;

   localparam logic signed [SUM_BITS-1:0] HALF =
      {{(SUM_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0] S_MAX =
      {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] S_MIN = ~S_MAX;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [PROD_BITS-1:0]  prod_ff[3][3];
   logic signed [PROD_BITS-1:0]  prod_in[3][3];
   logic signed [SUM_BITS-1:0]   acc[3];
   logic signed [SUM_BITS-1:0]   shifted[3];
   logic signed [COORD_BITS-1:0] res_ff[3];
   logic signed [COORD_BITS-1:0] res_in[3];
   logic                         valid1_ff;
   logic                         valid2_ff;
   logic [TAG_BITS-1:0]          tag1_ff;
   logic [TAG_BITS-1:0]          tag2_ff;

   // stage one: nine products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PROD_BITS'(coef[i][j]) * PROD_BITS'(in_vec[j]);
         end
      end
   end

   // stage two: row sums, round half up, saturate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = SUM_BITS'(prod_ff[i][0]) + SUM_BITS'(prod_ff[i][1])
                + SUM_BITS'(prod_ff[i][2]) + HALF;
         shifted[i] = acc[i] >>> FRAC_BITS;
         if (shifted[i] > S_MAX) begin
            res_in[i] = C_MAX;
         end else if (shifted[i] < S_MIN) begin
            res_in[i] = C_MIN;
         end else begin
            res_in[i] = shifted[i][COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         res_ff  <= res_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_tag   = tag2_ff;
   assign out_vec   = res_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cbbe_extent_table.sv
`default_nettype none

module cbbe_extent_table #(
   parameter int MAX_CLUSTERS = cbbe_pkg::MAX_CLUSTERS_DEF,
   parameter int COORD_BITS   = cbbe_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         upd_valid,
   input  cbbe_pkg::req_tag_type        upd_tag,
   input  logic signed [COORD_BITS-1:0] upd_q[3],
   output logic                         box_load,
   output logic signed [COORD_BITS-1:0] box_lo[3],
   output logic signed [COORD_BITS-1:0] box_hi[3],
   output logic                         box_empty
);
   import cbbe_pkg::*;

   localparam int IDX_BITS = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0] lo_ff[MAX_CLUSTERS][3];
   logic signed [COORD_BITS-1:0] hi_ff[MAX_CLUSTERS][3];
   logic [MAX_CLUSTERS-1:0]      occ_ff;
   logic [MAX_CLUSTERS-1:0]      occ_in;
   logic signed [COORD_BITS-1:0] lo_cur[3];
   logic signed [COORD_BITS-1:0] hi_cur[3];
   logic signed [COORD_BITS-1:0] lo_in[3];
   logic signed [COORD_BITS-1:0] hi_in[3];
   logic [LABEL_EXT_BITS-1:0]    lab_ext;
   logic [IDX_BITS-1:0]          idx;
   logic                         in_range;
   logic                         occ_hit;
   logic                         do_add;

   assign lab_ext  = LABEL_EXT_BITS'(upd_tag.label);
   assign in_range = lab_ext < LABEL_EXT_BITS'(MAX_CLUSTERS);
   assign idx      = lab_ext[IDX_BITS-1:0];
   assign occ_hit  = in_range && occ_ff[idx];
   assign do_add   = upd_valid && (upd_tag.kind == REQ_ADD) && in_range;

   // an entry that is not occupied reads as the empty sentinels
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_cur[k] = occ_hit ? lo_ff[idx][k] : C_MAX;
         hi_cur[k] = occ_hit ? hi_ff[idx][k] : C_MIN;
         lo_in[k]  = (upd_q[k] < lo_cur[k]) ? upd_q[k] : lo_cur[k];
         hi_in[k]  = (upd_q[k] > hi_cur[k]) ? upd_q[k] : hi_cur[k];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (upd_valid) begin
         case (upd_tag.kind)
            REQ_ADD: begin
               if (in_range) begin
                  occ_in[idx] = 1'b1;
               end
            end
            REQ_CLEAR: begin
               occ_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         for (int k = 0; k < 3; k++) begin
            lo_ff[idx][k] <= lo_in[k];
            hi_ff[idx][k] <= hi_in[k];
         end
      end
   end

   assign box_load  = upd_valid && (upd_tag.kind == REQ_READ);
   assign box_lo    = lo_cur;
   assign box_hi    = hi_cur;
   assign box_empty = !occ_hit;

endmodule

`default_nettype wire

// File: hw/rtl/cbbe_corner_seq.sv
`default_nettype none

module cbbe_corner_seq #(
   parameter int COORD_BITS = cbbe_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic signed [COORD_BITS-1:0]     lo[3],
   input  logic signed [COORD_BITS-1:0]     hi[3],
   input  logic                             empty,
   input  logic [cbbe_pkg::MARGIN_BITS-1:0] margin,
   input  logic                             adv,
   output logic                             sel_valid,
   output logic signed [COORD_BITS-1:0]     sel_vec[3],
   output cbbe_pkg::corner_tag_type         sel_tag
);
   import cbbe_pkg::*;

   localparam int SUM_BITS = COORD_BITS + 1;
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   logic signed [COORD_BITS-1:0] box_lo_ff[3];
   logic signed [COORD_BITS-1:0] box_hi_ff[3];
   logic                         empty_ff;
   logic                         busy_ff;
   logic [CORNER_BITS-1:0]       cnt_ff;
   logic signed [SUM_BITS-1:0]   hz_sum;
   logic signed [COORD_BITS-1:0] hz_sat;
   logic                         xs;

   // margin only grows the value, so only the top can overflow
   assign hz_sum = SUM_BITS'(hi[2]) + SUM_BITS'($signed({1'b0, margin}));
   assign hz_sat = (!hz_sum[SUM_BITS-1] && hz_sum[SUM_BITS-2]) ? C_MAX
                 : hz_sum[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff && adv) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST_CORNER) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         box_lo_ff    <= lo;
         box_hi_ff[0] <= hi[0];
         box_hi_ff[1] <= hi[1];
         box_hi_ff[2] <= hz_sat;
         empty_ff     <= empty;
      end
   end

   // corner order per level: (lo,lo) (hi,lo) (hi,hi) (lo,hi)
   assign xs = cnt_ff[0] ^ cnt_ff[1];

   always_comb begin
      sel_vec[0]    = xs        ? box_hi_ff[0] : box_lo_ff[0];
      sel_vec[1]    = cnt_ff[1] ? box_hi_ff[1] : box_lo_ff[1];
      sel_vec[2]    = cnt_ff[2] ? box_hi_ff[2] : box_lo_ff[2];
      sel_tag.index = cnt_ff;
      sel_tag.empty = empty_ff;
      sel_tag.last  = (cnt_ff == LAST_CORNER);
   end

   assign sel_valid = busy_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cbbe_checker.sv
`default_nettype none

module cbbe_checker #(
   parameter int COORD_BITS = cbbe_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [cbbe_pkg::REQ_TYPE_BITS-1:0] req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]  rsp_tdata,
   input  logic [cbbe_pkg::CORNER_BITS:0]     rsp_tuser,
   input  logic                               rsp_tlast
);
   import cbbe_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled response changed");

   // a read blocks further requests
   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == REQ_READ)) |=> !req_tready)
      else $error("request taken while a read is open");

   // last flag only on the final corner
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser[CORNER_BITS-1:0] == LAST_CORNER)))
      else $error("last flag out of place");

   // corners of one read leave back to back and in order
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tuser[CORNER_BITS-1:0] ==
            CORNER_BITS'($past(rsp_tuser[CORNER_BITS-1:0]) + 1'b1))))
      else $error("corner sequence broken");

   // the read closes with its last corner
   a_read_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("requests still blocked after last corner");

endmodule

bind cluster_bounding_box_engine_top cbbe_checker #(
   .COORD_BITS (COORD_BITS)
) u_cbbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
